@@ src/dual_channel_rms_meter_core_macros.svh @@
// Assertion macros shared by the verification checkers of the RMS meter core.
`ifndef DUAL_CHANNEL_RMS_METER_CORE_MACROS_SVH
`define DUAL_CHANNEL_RMS_METER_CORE_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define DCRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define DCRM_ASSERT_NOW(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/dcrm_pkg.sv @@
// Shared constants and types of the dual channel RMS meter.
package dcrm_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 12;
  localparam int SUM_BITS_DEFAULT    = 56;
  localparam int REG_BITS            = 16;
  localparam int FRAC_BITS           = 4;
  localparam int SCALE_SHIFT         = 12;
  localparam int RESULT_BITS         = 18;
  localparam int OUT_BITS            = ((2 * RESULT_BITS + 7) / 8) * 8;
  localparam int ADDR_BITS           = 4;
  localparam int DATA_BITS           = 32;

  localparam logic [1:0] REG_OFFSET  = 2'd0;
  localparam logic [1:0] REG_V_GAIN  = 2'd1;
  localparam logic [1:0] REG_C_GAIN  = 2'd2;
  localparam logic [1:0] REG_WINDOW  = 2'd3;

  localparam logic [REG_BITS-1:0] OFFSET_RESET = 16'd33155;
  localparam logic [REG_BITS-1:0] V_GAIN_RESET = 16'd29667;
  localparam logic [REG_BITS-1:0] C_GAIN_RESET = 16'd1753;
  localparam logic [REG_BITS-1:0] WINDOW_RESET = 16'd10000;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

endpackage

@@ src/dual_channel_rms_meter_core.sv @@
// Top level of the dual channel windowed RMS meter with its register port and control.
// The slave stream carries one voltage and current sample pair per transaction.
// Each pair is offset corrected, scaled by its channel gain, truncated toward
// zero, squared and added to a saturating sum of squares per channel.
// When the pair count reaches the window length, both sums are divided by the
// window, their integer square roots are taken, and one master transaction
// carries both results; the sums and the count then restart from zero.
// A pair passes through the bit-serial gain and square multiplications, which
// are MAG+4 bits wide, where MAG is the wider of SAMPLE_BITS+4 and 16; the next
// pair is accepted only once both channels have added their squares. At a
// window end the bit-serial divider and square root run, and no pair is taken,
// until the result is ready. Results pass through a holding stage and an
// output register, so new pairs are accepted while a result waits; a stalled
// receiver only blocks the next window end. Reset clears the sums, the count,
// pending results and loads the register defaults. Registers are to be written
// through the APB port only while idle; the block itself does not enforce this.
module dual_channel_rms_meter_core #(
  parameter int SAMPLE_BITS = dcrm_pkg::SAMPLE_BITS_DEFAULT,
  parameter int SUM_BITS    = dcrm_pkg::SUM_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // voltage_sample, current_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // rms_voltage, rms_current
  output logic [dcrm_pkg::OUT_BITS-1:0]        m_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dcrm_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [dcrm_pkg::DATA_BITS-1:0]       pwdata,
  output logic [dcrm_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_WAIT, S_ROOT} state_t;

  state_t                           state;
  logic [dcrm_pkg::REG_BITS-1:0]    offset_q4;
  logic [dcrm_pkg::REG_BITS-1:0]    voltage_gain_q8;
  logic [dcrm_pkg::REG_BITS-1:0]    current_gain_q8;
  logic [dcrm_pkg::REG_BITS-1:0]    window_length;
  logic [dcrm_pkg::REG_BITS-1:0]    sample_count;
  logic                             pending;

  logic [dcrm_pkg::REG_BITS-1:0]    win_eff;
  logic [dcrm_pkg::REG_BITS-1:0]    count_inc;
  logic                             win_end;
  logic                             accept;
  logic                             wr_en;
  logic                             div_start;
  logic                             acc_done;
  logic                             root_done;
  dcrm_pkg::acc_ctrl_t              acc_ctrl;

  logic [SUM_BITS-1:0]              v_sum;
  logic [SUM_BITS-1:0]              c_sum;
  logic                             v_done;
  logic                             c_done;
  logic [dcrm_pkg::RESULT_BITS-1:0] v_root;
  logic [dcrm_pkg::RESULT_BITS-1:0] c_root;
  logic                             v_rdone;
  logic                             c_rdone;

  always_comb begin
    s_tready  = (state == S_IDLE);
    accept    = s_tvalid && s_tready;
    pready    = 1'b1;
    wr_en     = psel && penable && pwrite && pready;
    win_eff   = (window_length == '0) ? dcrm_pkg::REG_BITS'(1) : window_length;
    count_inc = sample_count + 1'b1;
    win_end   = (count_inc >= win_eff);
    acc_done  = v_done && c_done;
    root_done = v_rdone && c_rdone;
    div_start = ((state == S_ACC) && acc_done && win_end && !pending) ||
                ((state == S_WAIT) && !pending);
    acc_ctrl.start = accept;
    acc_ctrl.clear = div_start;
  end

  always_comb begin
    unique case (paddr[3:2])
      dcrm_pkg::REG_OFFSET: prdata = dcrm_pkg::DATA_BITS'(offset_q4);
      dcrm_pkg::REG_V_GAIN: prdata = dcrm_pkg::DATA_BITS'(voltage_gain_q8);
      dcrm_pkg::REG_C_GAIN: prdata = dcrm_pkg::DATA_BITS'(current_gain_q8);
      dcrm_pkg::REG_WINDOW: prdata = dcrm_pkg::DATA_BITS'(window_length);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sample_count    <= '0;
      pending         <= 1'b0;
      m_tvalid        <= 1'b0;
      offset_q4       <= dcrm_pkg::OFFSET_RESET;
      voltage_gain_q8 <= dcrm_pkg::V_GAIN_RESET;
      current_gain_q8 <= dcrm_pkg::C_GAIN_RESET;
      window_length   <= dcrm_pkg::WINDOW_RESET;
    end else begin
      if (wr_en) begin
        unique case (paddr[3:2])
          dcrm_pkg::REG_OFFSET: offset_q4       <= pwdata[dcrm_pkg::REG_BITS-1:0];
          dcrm_pkg::REG_V_GAIN: voltage_gain_q8 <= pwdata[dcrm_pkg::REG_BITS-1:0];
          dcrm_pkg::REG_C_GAIN: current_gain_q8 <= pwdata[dcrm_pkg::REG_BITS-1:0];
          dcrm_pkg::REG_WINDOW: window_length   <= pwdata[dcrm_pkg::REG_BITS-1:0];
          default: ;
        endcase
      end

      if (pending && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= dcrm_pkg::OUT_BITS'({c_root, v_root});
        pending  <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_done) begin
            if (win_end) begin
              sample_count <= '0;
              state        <= pending ? S_WAIT : S_ROOT;
            end else begin
              sample_count <= count_inc;
              state        <= S_IDLE;
            end
          end
        end
        S_WAIT: begin
          if (!pending) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            pending <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dcrm_sqacc #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_v_acc (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (acc_ctrl),
    .sample(s_tdata[SAMPLE_BITS-1:0]),
    .offset(offset_q4),
    .gain  (voltage_gain_q8),
    .sum   (v_sum),
    .done  (v_done)
  );

  dcrm_sqacc #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_c_acc (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (acc_ctrl),
    .sample(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .offset(offset_q4),
    .gain  (current_gain_q8),
    .sum   (c_sum),
    .done  (c_done)
  );

  dcrm_divsqrt #(
    .SUM_BITS(SUM_BITS)
  ) u_v_root (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sum  (v_sum),
    .win  (win_eff),
    .root (v_root),
    .done (v_rdone)
  );

  dcrm_divsqrt #(
    .SUM_BITS(SUM_BITS)
  ) u_c_root (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sum  (c_sum),
    .win  (win_eff),
    .root (c_root),
    .done (c_rdone)
  );

endmodule

@@ src/dcrm_sqacc.sv @@
// Bit-serial offset, gain and square unit with a saturating sum of squares.
module dcrm_sqacc #(
  parameter int SAMPLE_BITS = dcrm_pkg::SAMPLE_BITS_DEFAULT,
  parameter int SUM_BITS    = dcrm_pkg::SUM_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcrm_pkg::acc_ctrl_t           ctrl,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [dcrm_pkg::REG_BITS-1:0] offset,
  input  logic [dcrm_pkg::REG_BITS-1:0] gain,
  output logic [SUM_BITS-1:0]           sum,
  output logic                          done
);

  localparam int MAG_BITS = (SAMPLE_BITS + dcrm_pkg::FRAC_BITS > dcrm_pkg::REG_BITS) ?
                            SAMPLE_BITS + dcrm_pkg::FRAC_BITS : dcrm_pkg::REG_BITS;
  localparam int SC_BITS  = MAG_BITS + dcrm_pkg::REG_BITS - dcrm_pkg::SCALE_SHIFT;
  localparam int SQ_BITS  = 2 * SC_BITS;
  localparam int ADD_BITS = ((SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS) + 1;
  localparam int CNT_BITS = $clog2(SC_BITS);

  typedef enum logic [1:0] {S_IDLE, S_GAIN, S_SQUARE, S_ADD} state_t;

  state_t               state;
  logic [CNT_BITS-1:0]  cnt;
  logic [SC_BITS-1:0]   mcand;
  logic [SC_BITS-1:0]   mplier;
  logic [SQ_BITS-1:0]   prod;

  logic [MAG_BITS-1:0]  q4;
  logic [MAG_BITS-1:0]  off_ext;
  logic [MAG_BITS-1:0]  mag;
  logic [SC_BITS:0]     add_sum;
  logic [SQ_BITS-1:0]   prod_step;
  logic [SC_BITS-1:0]   scaled;
  logic [ADD_BITS-1:0]  total;
  logic [SUM_BITS-1:0]  sum_sat;

  always_comb begin
    q4        = MAG_BITS'(sample) << dcrm_pkg::FRAC_BITS;
    off_ext   = MAG_BITS'(offset);
    mag       = (q4 >= off_ext) ? (q4 - off_ext) : (off_ext - q4);
    add_sum   = {1'b0, prod[SQ_BITS-1:SC_BITS]} + (mplier[0] ? {1'b0, mcand} : '0);
    prod_step = {add_sum, prod[SC_BITS-1:1]};
    scaled    = prod_step[SC_BITS+dcrm_pkg::SCALE_SHIFT-1:dcrm_pkg::SCALE_SHIFT];
    total     = ADD_BITS'(sum) + ADD_BITS'(prod);
    sum_sat   = (total > ADD_BITS'({SUM_BITS{1'b1}})) ? '1 : total[SUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_ADD);
      if (ctrl.clear) begin
        sum <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            mcand  <= SC_BITS'(mag);
            mplier <= SC_BITS'(gain);
            prod   <= '0;
            cnt    <= CNT_BITS'(SC_BITS - 1);
            state  <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (cnt == '0) begin
            mcand  <= scaled;
            mplier <= scaled;
            prod   <= '0;
            cnt    <= CNT_BITS'(SC_BITS - 1);
            state  <= S_SQUARE;
          end else begin
            prod   <= prod_step;
            mplier <= mplier >> 1;
            cnt    <= cnt - 1'b1;
          end
        end
        S_SQUARE: begin
          prod   <= prod_step;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          sum   <= sum_sat;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/dcrm_divsqrt.sv @@
// Bit-serial restoring divider followed by a two-bit-per-step integer square root.
module dcrm_divsqrt #(
  parameter int SUM_BITS = dcrm_pkg::SUM_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [SUM_BITS-1:0]              sum,
  input  logic [dcrm_pkg::REG_BITS-1:0]    win,
  output logic [dcrm_pkg::RESULT_BITS-1:0] root,
  output logic                             done
);

  localparam int RT_BITS   = (SUM_BITS + 1) / 2;
  localparam int V_BITS    = 2 * RT_BITS;
  localparam int SREM_BITS = RT_BITS + 2;
  localparam int DREM_BITS = dcrm_pkg::REG_BITS + 1;
  localparam int CNT_BITS  = $clog2(SUM_BITS);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} state_t;

  state_t                        state;
  logic [CNT_BITS-1:0]           cnt;
  logic [dcrm_pkg::REG_BITS-1:0] win_q;
  logic [SUM_BITS-1:0]           dq;
  logic [DREM_BITS-1:0]          drem;
  logic [V_BITS-1:0]             val;
  logic [SREM_BITS-1:0]          srem;
  logic [RT_BITS-1:0]            rt;

  logic [DREM_BITS-1:0]          dsh;
  logic                          dge;
  logic [SREM_BITS+1:0]          ssh;
  logic [SREM_BITS+1:0]          trial;
  logic                          sge;

  always_comb begin
    dsh   = {drem[dcrm_pkg::REG_BITS-1:0], dq[SUM_BITS-1]};
    dge   = dsh >= {1'b0, win_q};
    ssh   = {srem, val[V_BITS-1:V_BITS-2]};
    trial = (SREM_BITS + 2)'({rt, 2'b01});
    sge   = ssh >= trial;
    root  = (|rt[RT_BITS-1:dcrm_pkg::RESULT_BITS]) ? '1 : rt[dcrm_pkg::RESULT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_SQRT) && (cnt == '0);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dq    <= sum;
            drem  <= '0;
            win_q <= win;
            cnt   <= CNT_BITS'(SUM_BITS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= dge ? (dsh - {1'b0, win_q}) : dsh;
          dq   <= {dq[SUM_BITS-2:0], dge};
          if (cnt == '0) begin
            val   <= V_BITS'({dq[SUM_BITS-2:0], dge});
            srem  <= '0;
            rt    <= '0;
            cnt   <= CNT_BITS'(RT_BITS - 1);
            state <= S_SQRT;
          end else begin
            cnt   <= cnt - 1'b1;
          end
        end
        S_SQRT: begin
          srem <= SREM_BITS'(sge ? (ssh - trial) : ssh);
          rt   <= {rt[RT_BITS-2:0], sge};
          val  <= val << 2;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/dcrm_port_checker.sv @@
// Port-level assertion checker of the RMS meter core and its bind statement.
`include "dual_channel_rms_meter_core_macros.svh"

module dcrm_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dcrm_pkg::OUT_BITS-1:0] m_tdata
);

  `DCRM_ASSERT_NEXT(a_out_held, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `DCRM_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `DCRM_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken on back to back cycles")
  `DCRM_ASSERT_NOW(a_reset_clears_out, clk, $past(rst), !m_tvalid, "result valid right after reset")

endmodule

bind dual_channel_rms_meter_core dcrm_port_checker u_port_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the dual channel windowed RMS meter core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int S_BITS = ((2 * dcrm_pkg::SAMPLE_BITS_DEFAULT + 7) / 8) * 8;
  localparam bit [63:0] ACC_MAX = (64'd1 << dcrm_pkg::SUM_BITS_DEFAULT) - 64'd1;
  localparam bit [17:0] RMS_MAX = 18'h3FFFF;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENTS = 20;
  localparam int SEGMENT_PAIRS = 65;

  typedef struct packed {
    bit [17:0] rms_i;
    bit [17:0] rms_v;
  } rms_pair_t;

  class rms_window_tracker;
    bit [15:0] offset_q4;
    bit [15:0] v_gain;
    bit [15:0] i_gain;
    bit [15:0] window;
    bit [63:0] v_acc;
    bit [63:0] i_acc;
    bit [15:0] pairs;
    rms_pair_t rms_due[$];
    int errors;

    function new();
      offset_q4 = dcrm_pkg::OFFSET_RESET;
      v_gain = dcrm_pkg::V_GAIN_RESET;
      i_gain = dcrm_pkg::C_GAIN_RESET;
      window = dcrm_pkg::WINDOW_RESET;
      v_acc = 0;
      i_acc = 0;
      pairs = 0;
      errors = 0;
    endfunction

    function void load_reg(logic [1:0] idx, bit [15:0] val);
      case (idx)
        dcrm_pkg::REG_OFFSET: offset_q4 = val;
        dcrm_pkg::REG_V_GAIN: v_gain = val;
        dcrm_pkg::REG_C_GAIN: i_gain = val;
        dcrm_pkg::REG_WINDOW: window = val;
        default: ;
      endcase
    endfunction

    function bit [15:0] reg_value(logic [1:0] idx);
      case (idx)
        dcrm_pkg::REG_OFFSET: return offset_q4;
        dcrm_pkg::REG_V_GAIN: return v_gain;
        dcrm_pkg::REG_C_GAIN: return i_gain;
        default: return window;
      endcase
    endfunction

    function bit [63:0] scaled_square(bit [11:0] sample, bit [15:0] gain);
      bit [16:0] q4;
      bit [16:0] mag;
      bit [32:0] prod;
      bit [63:0] scaled;
      q4 = {1'b0, sample, 4'b0000};
      mag = (q4 >= offset_q4) ? q4 - offset_q4 : offset_q4 - q4;
      prod = mag * gain;
      scaled = prod >> dcrm_pkg::SCALE_SHIFT;
      return scaled * scaled;
    endfunction

    function bit [63:0] acc_add(bit [63:0] acc, bit [63:0] term);
      bit [64:0] total;
      total = acc + term;
      return (total > ACC_MAX) ? ACC_MAX : total[63:0];
    endfunction

    function bit [17:0] window_rms(bit [63:0] acc, bit [15:0] win);
      bit [63:0] mean;
      bit [63:0] root;
      bit [63:0] trial;
      mean = acc / win;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean) root = trial;
      end
      return (root > RMS_MAX) ? RMS_MAX : root[17:0];
    endfunction

    function void take_pair(bit [11:0] v_smp, bit [11:0] i_smp);
      bit [15:0] win;
      rms_pair_t res;
      win = (window == 0) ? 16'd1 : window;
      v_acc = acc_add(v_acc, scaled_square(v_smp, v_gain));
      i_acc = acc_add(i_acc, scaled_square(i_smp, i_gain));
      pairs = pairs + 16'd1;
      if (pairs >= win) begin
        res.rms_v = window_rms(v_acc, win);
        res.rms_i = window_rms(i_acc, win);
        rms_due.push_back(res);
        v_acc = 0;
        i_acc = 0;
        pairs = 0;
      end
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void match_result(bit [17:0] rms_v, bit [17:0] rms_i);
      rms_pair_t want;
      if (rms_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d/%0d arrived with none pending", rms_v, rms_i);
      end else begin
        want = rms_due.pop_front();
        if (want.rms_v != rms_v) flag("rms_voltage", want.rms_v, rms_v);
        if (want.rms_i != rms_i) flag("rms_current", want.rms_i, rms_i);
      end
    endfunction

    function int pending();
      return rms_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_BITS-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [dcrm_pkg::OUT_BITS-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dcrm_pkg::ADDR_BITS-1:0] paddr;
  logic [dcrm_pkg::DATA_BITS-1:0] pwdata;
  logic [dcrm_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  rms_window_tracker meter;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  dual_channel_rms_meter_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      meter.match_result(m_tdata[17:0], m_tdata[35:18]);
  end

  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_pair(bit [11:0] v_smp, bit [11:0] i_smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {i_smp, v_smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    meter.take_pair(v_smp, i_smp);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (meter.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register with junk in the unused upper bits, then reads it back.
  task automatic set_reg(logic [1:0] idx, bit [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom_range(0, 65535)), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    meter.load_reg(idx, val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, meter.reg_value(idx)})
      meter.flag("register readback", meter.reg_value(idx), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(bit [15:0] offs, bit [15:0] vg, bit [15:0] ig, bit [15:0] win);
    set_reg(dcrm_pkg::REG_OFFSET, offs);
    set_reg(dcrm_pkg::REG_V_GAIN, vg);
    set_reg(dcrm_pkg::REG_C_GAIN, ig);
    set_reg(dcrm_pkg::REG_WINDOW, win);
  endtask

  function automatic bit [11:0] pick_sample(bit [15:0] offs);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 12'd0;
      1: return 12'd4095;
      2: return offs[15:4];
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic bit [15:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r <= 5) return 16'($urandom_range(1, 4));
    if (r <= 8) return 16'($urandom_range(5, 20));
    return 16'($urandom_range(21, 60));
  endfunction

  initial begin
    bit [15:0] offs;
    meter = new();
    cycles = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Pairs under the reset settings stay in the sums of the next window.
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd0);
    settle();
    set_reg(dcrm_pkg::REG_WINDOW, 16'd1);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd0);
    send_pair(12'd2072, 12'd2072);
    send_pair(12'd2073, 12'd2071);
    settle();

    // Full gain with zero offset drives the root past the result range;
    // a zero window acts as a window of one.
    set_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd0);
    send_pair(12'd1, 12'd2048);
    send_pair(12'hAAA, 12'h555);
    settle();
    set_all(16'hFFFF, 16'd0, 16'd256, 16'd2);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd4095, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd0, 12'd0);
    settle();

    // Lowering the window below the count ends the window on the next pair.
    set_all(dcrm_pkg::OFFSET_RESET, dcrm_pkg::V_GAIN_RESET, dcrm_pkg::C_GAIN_RESET,
            16'hFFFF);
    repeat (5) send_pair(pick_sample(dcrm_pkg::OFFSET_RESET),
                         pick_sample(dcrm_pkg::OFFSET_RESET));
    settle();
    set_reg(dcrm_pkg::REG_WINDOW, 16'd3);
    send_pair(pick_sample(dcrm_pkg::OFFSET_RESET), pick_sample(dcrm_pkg::OFFSET_RESET));
    settle();

    // The receiver holds off long enough for the core to stall its input.
    set_reg(dcrm_pkg::REG_WINDOW, 16'd1);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (12) send_pair(pick_sample(dcrm_pkg::OFFSET_RESET),
                          pick_sample(dcrm_pkg::OFFSET_RESET));
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      offs = $urandom_range(0, 1) ? 16'($urandom_range(32000, 34000))
                                  : 16'($urandom_range(0, 65535));
      set_all(offs, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              pick_window());
      repeat (SEGMENT_PAIRS) send_pair(pick_sample(offs), pick_sample(offs));
      settle();
    end

    if (meter.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
